@@ sv/sitda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants for the decimal text formatter
// Holds the queue item type, the queue status group and the character and
// reciprocal constants that the front, queue and back modules use.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Width of the signed input value.
    localparam int VALUE_W = 32;
    // Width of one ASCII character code.
    localparam int CHAR_W = 7;
    // Default number of entries in the front-to-back queue.
    localparam int QUEUE_DEPTH = 2;
    // Most digits a 32-bit magnitude can have.
    localparam int MAX_DIGITS = 10;
    // Index width for the digit stack and its fill count.
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // Divide by ten as multiply by ceil(2^35 / 10), then shift right by 35.
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    // One classified number: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/sitda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_front: input side of the decimal text formatter
// Takes a transfer on start, splits the value into sign and magnitude and
// pushes it into the queue. Busy follows the queue being full.
// ----------------------------------------------------------------------------
module sitda_front (
    input  logic                          i_start,
    input  logic [sitda_pkg::VALUE_W-1:0] i_value,
    input  sitda_pkg::t_q_stat            i_stat,
    output logic                          o_push,
    output sitda_pkg::t_item              o_item,
    output logic                          o_busy
);
    import sitda_pkg::*;

    // The front can take an item whenever the queue has room.
    assign o_busy = i_stat.full;
    assign o_push = i_start & ~i_stat.full;

    // Two's complement magnitude; the most negative value maps to 2^31.
    always_comb begin
        o_item.neg = i_value[VALUE_W-1];
        o_item.mag = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
    end

endmodule

@@ sv/sitda_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_queue: short queue between the front and back parts
// A small circular buffer of classified numbers with a fill count.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sitda_queue #(
    parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sitda_pkg::t_item   i_item,
    input  logic               i_pop,
    output sitda_pkg::t_item   o_head,
    output sitda_pkg::t_q_stat o_stat
);
    import sitda_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    // Status and head entry.
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer wrap and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ sv/sitda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_back: digit generator and character output of the formatter
// Peels one decimal digit per cycle off the magnitude into a digit stack,
// then emits the optional minus sign and the digits most significant first.
// ----------------------------------------------------------------------------
module sitda_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sitda_pkg::t_item             i_head,
    input  sitda_pkg::t_q_stat           i_stat,
    output logic                         o_pop,
    output logic                         o_strobe,
    output logic [sitda_pkg::CHAR_W-1:0] o_char_code,
    output logic                         o_last
);
    import sitda_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic                   r_strobe, n_strobe;
    logic [CHAR_W-1:0]      r_char, n_char;
    logic                   r_last, n_last;
    logic                   r_neg, n_neg;
    logic [VALUE_W-1:0]     r_mag, n_mag;
    logic [DIGIT_CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]             r_digits [MAX_DIGITS];

    logic [2*VALUE_W-1:0]   w_prod;
    logic [VALUE_W-1:0]     w_quot;
    logic [VALUE_W-1:0]     w_quot10;
    logic [3:0]             w_digit;
    logic [DIGIT_CNT_W-1:0] w_top;
    logic                   w_wr_digit;

    // Divide the working magnitude by ten and take the remainder.
    always_comb begin
        w_prod   = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
        w_quot   = VALUE_W'(w_prod >> RECIP_SHIFT);
        w_quot10 = (w_quot << 3) + (w_quot << 1);
        w_digit  = 4'(r_mag - w_quot10);
    end

    assign w_top = r_cnt - DIGIT_CNT_W'(1);

    // Sequencer: load, divide, sign, emit.
    always_comb begin
        n_state    = r_state;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = r_last;
        n_neg      = r_neg;
        n_mag      = r_mag;
        n_cnt      = r_cnt;
        o_pop      = 1'b0;
        w_wr_digit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop   = 1'b1;
                    n_neg   = i_head.neg;
                    n_mag   = i_head.mag;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // At least one digit is produced, so zero gives a single '0'.
                w_wr_digit = 1'b1;
                n_mag      = w_quot;
                n_cnt      = r_cnt + DIGIT_CNT_W'(1);
                if (w_quot == '0) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
                n_last   = 1'b0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_char   = CHAR_ZERO + CHAR_W'(r_digits[w_top[DIGIT_CNT_W-1:0]]);
                n_last   = (r_cnt == DIGIT_CNT_W'(1));
                n_cnt    = w_top;
                if (r_cnt == DIGIT_CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers and digit stack.
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_cnt  <= n_cnt;
        if (w_wr_digit) begin
            r_digits[r_cnt] <= w_digit;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;

endmodule

@@ sv/signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
//
//   Channel  Handshake            Payload
//   input    start, busy          i_value (32-bit signed)
//   result   o_strobe (no stall)  o_char_code (7-bit ASCII), o_last
//
// The back part loads a number, divides out one digit per cycle, then
// emits an optional minus sign and the digits before it pops another number.
// The queue holds QUEUE_DEPTH numbers, so start is taken while a number is
// being printed; busy is high only while the queue is full.
// Reset is synchronous and clears the queue and the sequencer.
// Each character is shown for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = sitda_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [sitda_pkg::VALUE_W-1:0] i_value,
    output logic                          busy,
    output logic                          o_strobe,
    output logic [sitda_pkg::CHAR_W-1:0]  o_char_code,
    output logic                          o_last
);
    import sitda_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_item   w_item;
    t_item   w_head;
    t_q_stat w_stat;

    // Input side: classify and push.
    sitda_front u_front (
        .i_start (start),
        .i_value (i_value),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_item  (w_item),
        .o_busy  (busy)
    );

    // Queue between the two sides.
    sitda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    // Output side: digits and characters.
    sitda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

@@ sv/sitda_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_checker: port-level checks for the decimal text formatter
// Watches the top level ports and flags illegal character streams.
// ----------------------------------------------------------------------------
module sitda_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [sitda_pkg::CHAR_W-1:0]  o_char_code,
    input logic                          o_last
);
    import sitda_pkg::*;

    // Reset leaves no character transfer and a free input.
    a_rst_strobe: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("character strobe right after reset");
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // Only a minus sign or a decimal digit is ever sent.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_char_code == CHAR_MINUS) ||
                     ((o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_ZERO + 7'd9)))
        else $error("character outside minus and digits");

    // A minus sign never ends a number.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_char_code == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign marked last");

    // The characters of one number come without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a number");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);
